/* rtl/wprw_pkg.sv */
`default_nettype none

package wprw_pkg;

    localparam int TID_W = 6;
    localparam int KIND_W = 2;
    localparam int EVENT_W = 3;
    localparam int MAX_RESULTS = 16;
    localparam int BURST_W = $clog2(MAX_RESULTS + 1);

    localparam logic [KIND_W-1:0] KIND_ACQ_READ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REL_READ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACQ_WRITE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REL_WRITE = 2'd3;

    localparam logic [EVENT_W-1:0] EV_GRANT_READ = 3'd0;
    localparam logic [EVENT_W-1:0] EV_GRANT_WRITE = 3'd1;
    localparam logic [EVENT_W-1:0] EV_QUEUED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FULL = 3'd4;
    localparam logic [EVENT_W-1:0] EV_ERROR = 3'd5;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

`default_nettype wire

/* rtl/wprw_queue.sv */
`default_nettype none

module wprw_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic                      pop,
    input  wire logic [wprw_pkg::TID_W-1:0] push_id,
    output logic [wprw_pkg::TID_W-1:0]      pop_id,
    output wprw_pkg::qstat_t                stat
);
    import wprw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TID_W-1:0] mem [0:DEPTH-1];
    logic [TID_W-1:0] pop_id_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW:0]      tail_sum;
    logic [CW:0]      tail_wrap;
    logic [AW-1:0]    tail;

    // tail is head plus count, folded once
    always_comb
    begin
        tail_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
        if (tail_sum >= (CW + 1)'(DEPTH))
        begin
            tail_wrap = tail_sum - (CW + 1)'(DEPTH);
        end
        else
        begin
            tail_wrap = tail_sum;
        end
        tail = AW'(tail_wrap);
    end

    always_comb
    begin
        head_next = head_reg;
        count_next = count_reg;
        if (pop)
        begin
            if (head_reg == AW'(DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + AW'(1);
            end
        end
        case ({push, pop})
            2'b10:
            begin
                count_next = count_reg + CW'(1);
            end
            2'b01:
            begin
                count_next = count_reg - CW'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= push_id;
        end
        if (pop)
        begin
            pop_id_reg <= mem[head_reg];
        end
    end

    assign pop_id = pop_id_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

/* rtl/write_preferring_rw_lock_arbiter_top.sv */
// Reader-writer lock arbiter with writer preference. Raise start with kind and thread_id
// while busy is low; every request answers with one or more words on event_res,
// granted_thread and last, each shown for a single cycle under strobe, and the receiver
// cannot stall them. Grants, queueing, plain releases and errors answer in the cycle after
// the request and busy stays low, so one request per cycle is taken. A hand-over to a
// waiting writer waits in ST_GRANT_W, with busy high, for the read of the writer queue
// memory. A write release that wakes waiting readers stays in ST_BURST, with busy high,
// giving one word per reader woken (at most MAX_RESULTS), paced by the single read port
// of the reader queue memory; the last word of the burst carries last.
`default_nettype none

module write_preferring_rw_lock_arbiter_top #(
    parameter int MAX_THREADS = 64,
    parameter int WRITER_QUEUE_DEPTH = 16,
    parameter int READER_QUEUE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [wprw_pkg::KIND_W-1:0]  kind,
    input  wire logic [wprw_pkg::TID_W-1:0]   thread_id,
    output logic                             strobe,
    output logic [wprw_pkg::EVENT_W-1:0]      event_res,
    output logic [wprw_pkg::TID_W-1:0]        granted_thread,
    output logic                             last
);
    import wprw_pkg::*;

    localparam int RCW = $clog2(MAX_THREADS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GRANT_W,
        ST_BURST
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [RCW-1:0]     rc_reg;
    logic [RCW-1:0]     rc_next;
    logic               wh_reg;
    logic               wh_next;
    logic [BURST_W-1:0] burst_n_reg;
    logic [BURST_W-1:0] burst_n_next;
    logic               strobe_reg;
    logic               strobe_next;
    logic [EVENT_W-1:0] event_reg;
    logic [EVENT_W-1:0] event_next;
    logic [TID_W-1:0]   thread_reg;
    logic [TID_W-1:0]   thread_next;
    logic               last_reg;
    logic               last_next;

    logic               w_push;
    logic               w_pop;
    logic               r_push;
    logic               r_pop;
    logic [TID_W-1:0]   w_pop_id;
    logic [TID_W-1:0]   r_pop_id;
    qstat_t             w_stat;
    qstat_t             r_stat;
    logic               burst_end;

    wprw_queue #(
        .DEPTH(WRITER_QUEUE_DEPTH)
    ) u_wq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (w_push),
        .pop    (w_pop),
        .push_id(thread_id),
        .pop_id (w_pop_id),
        .stat   (w_stat)
    );

    wprw_queue #(
        .DEPTH(READER_QUEUE_DEPTH)
    ) u_rq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (r_push),
        .pop    (r_pop),
        .push_id(thread_id),
        .pop_id (r_pop_id),
        .stat   (r_stat)
    );

    assign burst_end = r_stat.empty || (burst_n_reg == BURST_W'(MAX_RESULTS));

    always_comb
    begin
        state_next = state_reg;
        rc_next = rc_reg;
        wh_next = wh_reg;
        burst_n_next = burst_n_reg;
        strobe_next = 1'b0;
        event_next = event_reg;
        thread_next = thread_reg;
        last_next = last_reg;
        w_push = 1'b0;
        w_pop = 1'b0;
        r_push = 1'b0;
        r_pop = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    last_next = 1'b1;
                    thread_next = '0;
                    case (kind)
                        KIND_ACQ_READ:
                        begin
                            if (!wh_reg && w_stat.empty)
                            begin
                                if (rc_reg == RCW'(MAX_THREADS))
                                begin
                                    event_next = EV_FULL;
                                end
                                else
                                begin
                                    rc_next = rc_reg + RCW'(1);
                                    event_next = EV_GRANT_READ;
                                    thread_next = thread_id;
                                end
                            end
                            else if (!r_stat.full)
                            begin
                                r_push = 1'b1;
                                event_next = EV_QUEUED;
                                thread_next = thread_id;
                            end
                            else
                            begin
                                event_next = EV_FULL;
                            end
                        end
                        KIND_REL_READ:
                        begin
                            if (rc_reg == '0)
                            begin
                                event_next = EV_ERROR;
                            end
                            else
                            begin
                                rc_next = rc_reg - RCW'(1);
                                if (rc_reg == RCW'(1) && !w_stat.empty)
                                begin
                                    // last reader out hands over to the oldest writer
                                    w_pop = 1'b1;
                                    wh_next = 1'b1;
                                    strobe_next = 1'b0;
                                    state_next = ST_GRANT_W;
                                end
                                else
                                begin
                                    event_next = EV_RELEASED;
                                end
                            end
                        end
                        KIND_ACQ_WRITE:
                        begin
                            if (!wh_reg && rc_reg == '0)
                            begin
                                wh_next = 1'b1;
                                event_next = EV_GRANT_WRITE;
                                thread_next = thread_id;
                            end
                            else if (!w_stat.full)
                            begin
                                w_push = 1'b1;
                                event_next = EV_QUEUED;
                                thread_next = thread_id;
                            end
                            else
                            begin
                                event_next = EV_FULL;
                            end
                        end
                        KIND_REL_WRITE:
                        begin
                            if (!wh_reg)
                            begin
                                event_next = EV_ERROR;
                            end
                            else if (!w_stat.empty)
                            begin
                                w_pop = 1'b1;
                                strobe_next = 1'b0;
                                state_next = ST_GRANT_W;
                            end
                            else if (r_stat.empty)
                            begin
                                wh_next = 1'b0;
                                event_next = EV_RELEASED;
                            end
                            else
                            begin
                                // wake waiting readers, one memory read per word
                                wh_next = 1'b0;
                                r_pop = 1'b1;
                                if (rc_reg != RCW'(MAX_THREADS))
                                begin
                                    rc_next = rc_reg + RCW'(1);
                                end
                                burst_n_next = BURST_W'(1);
                                strobe_next = 1'b0;
                                state_next = ST_BURST;
                            end
                        end
                        default:
                        begin
                            event_next = EV_ERROR;
                        end
                    endcase
                end
            end
            ST_GRANT_W:
            begin
                strobe_next = 1'b1;
                event_next = EV_GRANT_WRITE;
                thread_next = w_pop_id;
                last_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BURST:
            begin
                strobe_next = 1'b1;
                event_next = EV_GRANT_READ;
                thread_next = r_pop_id;
                last_next = burst_end;
                if (burst_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_pop = 1'b1;
                    if (rc_reg != RCW'(MAX_THREADS))
                    begin
                        rc_next = rc_reg + RCW'(1);
                    end
                    burst_n_next = burst_n_reg + BURST_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rc_reg <= '0;
            wh_reg <= 1'b0;
            burst_n_reg <= '0;
            strobe_reg <= 1'b0;
            event_reg <= '0;
            thread_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg <= rc_next;
            wh_reg <= wh_next;
            burst_n_reg <= burst_n_next;
            strobe_reg <= strobe_next;
            event_reg <= event_next;
            thread_reg <= thread_next;
            last_reg <= last_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign event_res = event_reg;
    assign granted_thread = thread_reg;
    assign last = last_reg;

endmodule

`default_nettype wire

/* tb/lock_event_checker.sv */
`timescale 1ns / 1ps

module lock_event_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [wprw_pkg::KIND_W-1:0]  kind,
    input  wire logic [wprw_pkg::TID_W-1:0]   thread_id,
    input  wire logic                         strobe,
    input  wire logic [wprw_pkg::EVENT_W-1:0] event_res,
    input  wire logic [wprw_pkg::TID_W-1:0]   granted_thread,
    input  wire logic                         last,
    output int                                fail_count,
    output int                                outstanding
);
    import wprw_pkg::*;

    localparam int MAX_THREADS = 64;
    localparam int WRITER_QUEUE_DEPTH = 16;
    localparam int READER_QUEUE_DEPTH = 16;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [TID_W-1:0]   tid;
        logic               last;
    } lock_word_t;

    lock_word_t       pending_words[$];
    logic [TID_W-1:0] writer_fifo[$];
    logic [TID_W-1:0] reader_fifo[$];
    int               active_readers = 0;
    logic             writer_owns = 1'b0;
    int               mismatches = 0;

    function automatic void add_expected(input logic [EVENT_W-1:0] ev,
                                         input logic [TID_W-1:0] tid, input logic lst);
        lock_word_t w;
        w.ev = ev;
        w.tid = tid;
        w.last = lst;
        pending_words.push_back(w);
    endfunction

    task automatic predict_lock_request(input logic [KIND_W-1:0] k,
                                        input logic [TID_W-1:0] tid);
        logic [TID_W-1:0] woken;
        int               n;
        case (k)
            KIND_ACQ_READ:
            begin
                if (!writer_owns && writer_fifo.size() == 0)
                begin
                    if (active_readers >= MAX_THREADS)
                        add_expected(EV_FULL, '0, 1'b1);
                    else
                    begin
                        active_readers++;
                        add_expected(EV_GRANT_READ, tid, 1'b1);
                    end
                end
                else if (reader_fifo.size() < READER_QUEUE_DEPTH)
                begin
                    reader_fifo.push_back(tid);
                    add_expected(EV_QUEUED, tid, 1'b1);
                end
                else
                    add_expected(EV_FULL, '0, 1'b1);
            end
            KIND_REL_READ:
            begin
                if (active_readers == 0)
                    add_expected(EV_ERROR, '0, 1'b1);
                else
                begin
                    active_readers--;
                    if (active_readers == 0 && writer_fifo.size() > 0)
                    begin
                        woken = writer_fifo.pop_front();
                        writer_owns = 1'b1;
                        add_expected(EV_GRANT_WRITE, woken, 1'b1);
                    end
                    else
                        add_expected(EV_RELEASED, '0, 1'b1);
                end
            end
            KIND_ACQ_WRITE:
            begin
                if (!writer_owns && active_readers == 0)
                begin
                    writer_owns = 1'b1;
                    add_expected(EV_GRANT_WRITE, tid, 1'b1);
                end
                else if (writer_fifo.size() < WRITER_QUEUE_DEPTH)
                begin
                    writer_fifo.push_back(tid);
                    add_expected(EV_QUEUED, tid, 1'b1);
                end
                else
                    add_expected(EV_FULL, '0, 1'b1);
            end
            default:
            begin
                if (!writer_owns)
                    add_expected(EV_ERROR, '0, 1'b1);
                else if (writer_fifo.size() > 0)
                begin
                    woken = writer_fifo.pop_front();
                    add_expected(EV_GRANT_WRITE, woken, 1'b1);
                end
                else
                begin
                    writer_owns = 1'b0;
                    if (reader_fifo.size() == 0)
                        add_expected(EV_RELEASED, '0, 1'b1);
                    else
                    begin
                        // reader wake burst
                        n = 0;
                        while (reader_fifo.size() > 0 && n < MAX_RESULTS)
                        begin
                            woken = reader_fifo.pop_front();
                            if (active_readers < MAX_THREADS)
                                active_readers++;
                            n++;
                            add_expected(EV_GRANT_READ, woken,
                                         reader_fifo.size() == 0 || n == MAX_RESULTS);
                        end
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        lock_word_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: event %0d thread %0d last %0d",
                                 event_res, granted_thread, last);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (want.ev !== event_res || want.tid !== granted_thread
                        || want.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.ev, want.tid, want.last,
                                     event_res, granted_thread, last);
                    end
                end
            end
            if (start && !busy)
                predict_lock_request(kind, thread_id);
        end
        fail_count <= mismatches;
        outstanding <= pending_words.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import wprw_pkg::*;

    localparam int ITEM_TOTAL = 330;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [KIND_W-1:0]  kind = KIND_ACQ_READ;
    logic [TID_W-1:0]   thread_id = '0;
    logic               busy;
    logic               strobe;
    logic [EVENT_W-1:0] event_res;
    logic [TID_W-1:0]   granted_thread;
    logic               last;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count = 0;
    int                 sent = 0;

    always #6 clk = ~clk;

    write_preferring_rw_lock_arbiter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .thread_id      (thread_id),
        .strobe         (strobe),
        .event_res      (event_res),
        .granted_thread (granted_thread),
        .last           (last)
    );

    lock_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .thread_id      (thread_id),
        .strobe         (strobe),
        .event_res      (event_res),
        .granted_thread (granted_thread),
        .last           (last),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [TID_W-1:0] any_tid();
        return TID_W'($urandom_range(63));
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] k, input logic [TID_W-1:0] tid);
        // random idle gaps, but none in a stretch in the middle of the run
        if (!(sent >= 150 && sent < 240) && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        thread_id <= tid;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic lock_pileup();
        int nw;
        int nr;
        bit read_first;
        nw = $urandom_range(0, 18);
        nr = $urandom_range(0, 18);
        read_first = 1'($urandom_range(1));
        send_request(read_first ? KIND_ACQ_READ : KIND_ACQ_WRITE, any_tid());
        repeat (nw) send_request(KIND_ACQ_WRITE, any_tid());
        repeat (nr) send_request(KIND_ACQ_READ, any_tid());
        if (read_first)
            send_request(KIND_REL_READ, any_tid());
        repeat (nw + (read_first ? 0 : 1)) send_request(KIND_REL_WRITE, any_tid());
        repeat (nr + (read_first ? 1 : 0)) send_request(KIND_REL_READ, any_tid());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // releases with no holder, then directed acquire, queueing and hand-over cases
        send_request(KIND_REL_READ, 6'd63);
        send_request(KIND_REL_WRITE, 6'd0);
        send_request(KIND_ACQ_READ, 6'd0);
        send_request(KIND_ACQ_READ, 6'd63);
        send_request(KIND_ACQ_WRITE, 6'd21);
        send_request(KIND_ACQ_READ, 6'd42);
        send_request(KIND_REL_READ, 6'd0);
        send_request(KIND_REL_READ, 6'd63);
        send_request(KIND_ACQ_WRITE, 6'd5);
        send_request(KIND_ACQ_READ, 6'd63);
        send_request(KIND_REL_WRITE, 6'd0);
        send_request(KIND_REL_WRITE, 6'd63);
        send_request(KIND_REL_READ, 6'd0);
        send_request(KIND_REL_READ, 6'd0);
        send_request(KIND_REL_READ, 6'd0);
        send_request(KIND_ACQ_WRITE, 6'd63);
        send_request(KIND_ACQ_WRITE, 6'd0);
        send_request(KIND_REL_WRITE, 6'd42);
        send_request(KIND_REL_WRITE, 6'd42);
        send_request(KIND_REL_WRITE, 6'd42);

        // reader count up to its limit and back
        repeat (66) send_request(KIND_ACQ_READ, any_tid());
        repeat (66) send_request(KIND_REL_READ, any_tid());

        while (sent < ITEM_TOTAL)
        begin
            if ($urandom_range(99) < 35)
                send_request(KIND_W'($urandom_range(3)), any_tid());
            else
                lock_pileup();
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wprw_pkg.sv
rtl/wprw_queue.sv
rtl/write_preferring_rw_lock_arbiter_top.sv
tb/lock_event_checker.sv
tb/tb_top.sv
